>>> rtl/core/mctt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctt_pkg: MIDI clock tempo tracker shared definitions
// Request and result payload types, function codes, register indexes, constants and the
// sequencer state type.
// ----------------------------------------------------------------------------
package mctt_pkg;

    localparam int WINDOW_DEFAULT = 8;

    localparam int TICKS_PER_BEAT = 24;
    localparam int STOP_TICKS     = 5;
    localparam int TEMPO_SCALE    = 2500;
    localparam int SPP_TICK_STEP  = 6;
    localparam int SPP_PER_BEAT   = 4;

    localparam logic [15:0] MARGIN_RESET = 16'd5;
    localparam logic [7:0]  LIMIT_RESET  = 8'd3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

    localparam logic [2:0] FUNC_CLOCK    = 3'd0;
    localparam logic [2:0] FUNC_START    = 3'd1;
    localparam logic [2:0] FUNC_CONTINUE = 3'd2;
    localparam logic [2:0] FUNC_STOP     = 3'd3;
    localparam logic [2:0] FUNC_SPP      = 3'd4;
    localparam logic [2:0] FUNC_HK_TICK  = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] timestamp_ms;
        logic [6:0]  spp_low;
        logic [6:0]  spp_high;
    } t_in;

    typedef struct packed {
        logic        playing;
        logic        advance;
        logic [15:0] tempo_bpm;
        logic [15:0] beat_count;
        logic [4:0]  tick_in_beat;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_MUL,
        S_CHK,
        S_DIV,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> rtl/core/midi_clock_tempo_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_clock_tempo_tracker: MIDI transport and tempo follower
// Tracks start/continue/stop/song position, counts beats and ticks, and
// averages clock intervals over a window held in a small memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------
//  in       | input     | i_in_valid / o_in_stall   | i_in_data  t_in
//  out      | output    | o_out_valid / i_out_stall | o_out_data t_out
//  cfg      | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  One request at a time. A non-clock request, or the first clock, goes from
//  idle straight to done; a measured clock steps through push, multiply, check
//  and the radix-2 tempo divider (skipped when the tempo saturates), then done.
//  Reset clears control and tracking state; window entries are used only once written.
//  The result register holds while i_out_stall is high; the next request is
//  taken meanwhile and waits in the done state for the register.
// ----------------------------------------------------------------------------
module midi_clock_tempo_tracker #(
    parameter int WINDOW = mctt_pkg::WINDOW_DEFAULT
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  mctt_pkg::t_in                 i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output mctt_pkg::t_out                      o_out_data,
    input  wire                                 i_cfg_we,
    input  wire  [mctt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [mctt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mctt_pkg::*;

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = 32 + $clog2(WINDOW);
    localparam int PW = 32 + CW;
    localparam int MW = 16 + CW;
    localparam int DW = PW + 1;
    localparam int NW = SW + 1;
    localparam int QW = SW + 17;

    t_state r_state, n_state;

    logic [15:0]   r_margin, n_margin;
    logic [7:0]    r_limit, n_limit;
    logic [31:0]   r_prev, n_prev;
    logic [IW-1:0] r_widx, n_widx;
    logic          r_full, n_full;
    logic [SW-1:0] r_sum, n_sum;
    logic [7:0]    r_outl, n_outl;
    logic          r_ppl, n_ppl;
    logic          r_pst, n_pst;
    logic          r_run, n_run;
    logic [2:0]    r_cd, n_cd;
    logic [15:0]   r_beats, n_beats;
    logic [4:0]    r_ticks, n_ticks;
    logic [15:0]   r_tempo, n_tempo;
    logic          r_adv, n_adv;
    logic [31:0]   r_delta, n_delta;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_scaled, n_scaled;
    logic [MW-1:0] r_mg, n_mg;
    logic [NW-1:0] r_num, n_num;
    logic [NW-1:0] r_den, n_den;
    logic [QW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_dsh, n_dsh;
    logic [15:0]   r_quo, n_quo;
    logic [3:0]    r_bit, n_bit;
    logic          r_ovalid, n_ovalid;
    t_out          r_odata, n_odata;

    logic [31:0]   mem [WINDOW];
    logic [31:0]   r_rd;

    logic          in_acc;
    logic          measure;
    logic          out_free;
    logic          sum_zero;
    logic          div_big;
    logic          div_ge;
    logic [CW-1:0] idx_ext;
    logic [13:0]   spp_pos;
    logic          in_band;
    logic [7:0]    outl_inc;
    logic [7:0]    lim_eff;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign measure  = (i_in_data.func == FUNC_CLOCK) && (r_prev != '0);
    assign out_free = !r_ovalid || !i_out_stall;
    assign sum_zero = (r_sum == '0);
    assign div_big  = QW'(r_num) >= (QW'(r_den) << 16);
    assign div_ge   = r_rem >= r_dsh;
    assign idx_ext  = CW'(r_widx) + CW'(1);
    assign spp_pos  = {i_in_data.spp_high, i_in_data.spp_low};

    // strict band: sum - m < delta*cnt < sum + m
    assign in_band  = ((DW'(r_scaled) + DW'(r_mg)) > DW'(r_sum)) &&
                      (DW'(r_scaled) < (DW'(r_sum) + DW'(r_mg)));
    assign outl_inc = (r_outl == 8'hFF) ? r_outl : r_outl + 8'd1;
    assign lim_eff  = (r_limit == '0) ? 8'd1 : r_limit;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = measure ? S_PUSH : S_DONE;
                end
            end
            S_PUSH: n_state = S_MUL;
            S_MUL:  n_state = S_CHK;
            S_CHK:  n_state = (sum_zero || div_big) ? S_DONE : S_DIV;
            S_DIV: begin
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_margin = r_margin;
        n_limit  = r_limit;
        n_prev   = r_prev;
        n_widx   = r_widx;
        n_full   = r_full;
        n_sum    = r_sum;
        n_outl   = r_outl;
        n_ppl    = r_ppl;
        n_pst    = r_pst;
        n_run    = r_run;
        n_cd     = r_cd;
        n_beats  = r_beats;
        n_ticks  = r_ticks;
        n_tempo  = r_tempo;
        n_adv    = r_adv;
        n_delta  = r_delta;
        n_cnt    = r_cnt;
        n_scaled = r_scaled;
        n_mg     = r_mg;
        n_num    = r_num;
        n_den    = r_den;
        n_rem    = r_rem;
        n_dsh    = r_dsh;
        n_quo    = r_quo;
        n_bit    = r_bit;
        n_ovalid = r_ovalid && i_out_stall;
        n_odata  = r_odata;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MARGIN: n_margin = i_cfg_data;
                CFG_LIMIT:  n_limit  = i_cfg_data[7:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_adv = 1'b0;
                    unique case (i_in_data.func)
                        FUNC_CLOCK: begin
                            if (r_ppl) begin
                                n_run = 1'b1;
                                n_ppl = 1'b0;
                            end
                            n_delta = i_in_data.timestamp_ms - r_prev;
                            n_prev  = i_in_data.timestamp_ms;
                            if (r_ppl || r_run) begin
                                n_adv = 1'b1;
                                if (r_ticks >= 5'(TICKS_PER_BEAT - 1)) begin
                                    n_ticks = '0;
                                    n_beats = r_beats + 16'd1;
                                end else begin
                                    n_ticks = r_ticks + 5'd1;
                                end
                            end
                        end
                        FUNC_START: begin
                            n_ppl   = 1'b1;
                            n_pst   = 1'b0;
                            n_beats = '0;
                            n_ticks = '0;
                        end
                        FUNC_CONTINUE: begin
                            n_ppl = 1'b1;
                            n_pst = 1'b0;
                        end
                        FUNC_STOP: begin
                            n_cd  = 3'(STOP_TICKS);
                            n_pst = 1'b1;
                            n_ppl = 1'b0;
                        end
                        FUNC_SPP: begin
                            n_beats = 16'(spp_pos / SPP_PER_BEAT);
                            n_ticks = 5'(spp_pos[1:0]) * 5'(SPP_TICK_STEP);
                        end
                        FUNC_HK_TICK: begin
                            if (r_pst) begin
                                if (r_cd != '0) begin
                                    n_cd = r_cd - 3'd1;
                                end
                                if (r_cd <= 3'd1) begin
                                    n_run = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PUSH: begin
                // r_rd holds the entry being replaced
                n_sum = r_sum - (r_full ? SW'(r_rd) : SW'(0)) + SW'(r_delta);
                if (idx_ext == CW'(WINDOW)) begin
                    n_widx = '0;
                    n_full = 1'b1;
                end else begin
                    n_widx = IW'(idx_ext);
                end
                n_cnt = n_full ? CW'(WINDOW) : idx_ext;
            end
            S_MUL: begin
                n_scaled = PW'(r_delta) * PW'(r_cnt);
                n_mg     = MW'(r_margin) * MW'(r_cnt);
                n_num    = NW'(2 * TEMPO_SCALE) * NW'(r_cnt) + NW'(r_sum);
                n_den    = {r_sum, 1'b0};
            end
            S_CHK: begin
                if (sum_zero || div_big) begin
                    n_tempo = 16'hFFFF;
                end
                n_rem = QW'(r_num);
                n_dsh = QW'(r_den) << 15;
                n_quo = '0;
                n_bit = 4'd15;
                if (in_band) begin
                    n_outl = '0;
                end else if (outl_inc >= lim_eff) begin
                    n_widx = '0;
                    n_full = 1'b0;
                    n_sum  = '0;
                    n_outl = '0;
                end else begin
                    n_outl = outl_inc;
                end
            end
            S_DIV: begin
                if (div_ge) begin
                    n_rem = r_rem - r_dsh;
                    n_quo = r_quo | (16'd1 << r_bit);
                end
                n_dsh = r_dsh >> 1;
                n_bit = r_bit - 4'd1;
                if (r_bit == '0) begin
                    n_tempo = n_quo;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid             = 1'b1;
                    n_odata.playing      = r_run;
                    n_odata.advance      = r_adv;
                    n_odata.tempo_bpm    = r_tempo;
                    n_odata.beat_count   = r_beats;
                    n_odata.tick_in_beat = r_ticks;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_margin <= MARGIN_RESET;
            r_limit  <= LIMIT_RESET;
            r_prev   <= '0;
            r_widx   <= '0;
            r_full   <= 1'b0;
            r_sum    <= '0;
            r_outl   <= '0;
            r_ppl    <= 1'b0;
            r_pst    <= 1'b0;
            r_run    <= 1'b0;
            r_cd     <= '0;
            r_beats  <= '0;
            r_ticks  <= '0;
            r_tempo  <= '0;
            r_adv    <= 1'b0;
            r_bit    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_margin <= n_margin;
            r_limit  <= n_limit;
            r_prev   <= n_prev;
            r_widx   <= n_widx;
            r_full   <= n_full;
            r_sum    <= n_sum;
            r_outl   <= n_outl;
            r_ppl    <= n_ppl;
            r_pst    <= n_pst;
            r_run    <= n_run;
            r_cd     <= n_cd;
            r_beats  <= n_beats;
            r_ticks  <= n_ticks;
            r_tempo  <= n_tempo;
            r_adv    <= n_adv;
            r_bit    <= n_bit;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_delta  <= n_delta;
        r_cnt    <= n_cnt;
        r_scaled <= n_scaled;
        r_mg     <= n_mg;
        r_num    <= n_num;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_dsh    <= n_dsh;
        r_quo    <= n_quo;
        r_odata  <= n_odata;
    end

    // interval window: read the slot to be replaced while idle, write on push
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) begin
            mem[r_widx] <= r_delta;
        end
        if (r_state == S_IDLE) begin
            r_rd <= mem[r_widx];
        end
    end

`ifndef ASSERT_OFF
    a_rose_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result valid rose outside done state");

    a_ticks_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ticks < 5'(TICKS_PER_BEAT))
        else $error("tick within beat out of range");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((QW + 1)'(r_rem) < ((QW + 1)'(r_dsh) << 1)))
        else $error("divider remainder exceeds bound");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

    a_countdown_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cd <= 3'(STOP_TICKS))
        else $error("stop countdown out of range");
`endif

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: MIDI clock tempo tracker testbench
// A queue-fed driver offers transport and clock requests and a clocked monitor
// checks every status result against a cycle-free tracker model kept here.
// The run goes through directed corner cases and then random song-like
// sequences under several margin/limit settings and stall patterns.
// ----------------------------------------------------------------------------
module tb;
    import mctt_pkg::*;

    localparam int WIN         = WINDOW_DEFAULT;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    midi_clock_tempo_tracker #(.WINDOW(WIN)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_in  midi_req_q[$];
    t_out expected_status_q[$];
    int   reqs_queued   = 0;
    int   reqs_accepted = 0;
    int   mismatches    = 0;
    logic req_fire      = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_cnt      = 0;

    // tracker model state
    logic [15:0]  trk_margin    = MARGIN_RESET;
    logic [7:0]   trk_limit     = LIMIT_RESET;
    logic [31:0]  trk_prev_ts   = '0;
    logic [31:0]  trk_win [WIN];
    int unsigned  trk_idx       = 0;
    logic         trk_full      = 1'b0;
    logic [34:0]  trk_sum       = '0;
    int unsigned  trk_outliers  = 0;
    logic         trk_pend_play = 1'b0;
    logic         trk_pend_stop = 1'b0;
    logic         trk_running   = 1'b0;
    int unsigned  trk_countdown = 0;
    logic [15:0]  trk_beat      = '0;
    logic [4:0]   trk_tick      = '0;
    logic [15:0]  trk_tempo     = '0;

    // stimulus generator state
    logic [31:0]  gen_now  = 32'd1000;
    int           gen_base = 20;

    function automatic logic track_clock(logic [31:0] ts);
        logic [31:0]       delta;
        longint            cnt;
        longint            scaled;
        longint            sum;
        longint            m;
        longint unsigned   q;
        int unsigned       lim;
        if (trk_pend_play) begin
            trk_running   = 1'b1;
            trk_pend_play = 1'b0;
        end
        if (trk_prev_ts != 0) begin
            delta = ts - trk_prev_ts;
            if (trk_full)
                trk_sum = trk_sum - trk_win[trk_idx];
            trk_win[trk_idx] = delta;
            trk_sum = trk_sum + delta;
            if (trk_idx == WIN - 1) begin
                trk_idx  = 0;
                trk_full = 1'b1;
            end else begin
                trk_idx++;
            end
            cnt = trk_full ? WIN : trk_idx;
            if (trk_sum == 0) begin
                trk_tempo = 16'hFFFF;
            end else begin
                q = (longint'(2 * TEMPO_SCALE) * cnt + trk_sum) / (2 * trk_sum);
                trk_tempo = (q > 65535) ? 16'hFFFF : q[15:0];
            end
            // average kept as sum/count, so compare scaled by count
            scaled = longint'({32'd0, delta}) * cnt;
            sum    = longint'({29'd0, trk_sum});
            m      = longint'({48'd0, trk_margin}) * cnt;
            lim    = (trk_limit == 0) ? 1 : trk_limit;
            if (scaled > sum - m && scaled < sum + m) begin
                trk_outliers = 0;
            end else begin
                if (trk_outliers < 255)
                    trk_outliers++;
                if (trk_outliers >= lim) begin
                    trk_idx      = 0;
                    trk_full     = 1'b0;
                    trk_sum      = '0;
                    trk_outliers = 0;
                end
            end
        end
        trk_prev_ts = ts;
        if (!trk_running)
            return 1'b0;
        if (trk_tick + 1 >= TICKS_PER_BEAT) begin
            trk_tick = '0;
            trk_beat = trk_beat + 16'd1;
        end else begin
            trk_tick = trk_tick + 5'd1;
        end
        return 1'b1;
    endfunction

    function automatic t_out predict_status(t_in req);
        t_out        res;
        logic        adv;
        logic [13:0] pos;
        adv = 1'b0;
        pos = {req.spp_high, req.spp_low};
        case (req.func)
            FUNC_CLOCK: begin
                adv = track_clock(req.timestamp_ms);
            end
            FUNC_START: begin
                trk_pend_play = 1'b1;
                trk_pend_stop = 1'b0;
                trk_beat      = '0;
                trk_tick      = '0;
            end
            FUNC_CONTINUE: begin
                trk_pend_play = 1'b1;
                trk_pend_stop = 1'b0;
            end
            FUNC_STOP: begin
                trk_countdown = STOP_TICKS;
                trk_pend_stop = 1'b1;
                trk_pend_play = 1'b0;
            end
            FUNC_SPP: begin
                trk_beat = 16'(pos / SPP_PER_BEAT);
                trk_tick = 5'((pos % SPP_PER_BEAT) * SPP_TICK_STEP);
            end
            FUNC_HK_TICK: begin
                if (trk_pend_stop) begin
                    if (trk_countdown > 0)
                        trk_countdown--;
                    if (trk_countdown == 0)
                        trk_running = 1'b0;
                end
            end
            default: ;
        endcase
        res.playing      = trk_running;
        res.advance      = adv;
        res.tempo_bpm    = trk_tempo;
        res.beat_count   = trk_beat;
        res.tick_in_beat = trk_tick;
        return res;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // monitor: requests are predicted as they are taken, results checked in order
    always @(posedge i_clk) begin
        t_out want;
        req_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_status_q.push_back(predict_status(i_in_data));
                reqs_accepted++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_status_q.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("playing", want.playing, o_out_data.playing);
                    check_field("advance", want.advance, o_out_data.advance);
                    check_field("tempo_bpm", want.tempo_bpm, o_out_data.tempo_bpm);
                    check_field("beat_count", want.beat_count, o_out_data.beat_count);
                    check_field("tick_in_beat", want.tick_in_beat,
                                o_out_data.tick_in_beat);
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_fire) begin
            if (midi_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data  <= midi_req_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result stall, with one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES)
                hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic push_req(logic [2:0] fn, logic [31:0] ts, logic [6:0] lo,
                            logic [6:0] hi);
        t_in r;
        r.func         = fn;
        r.timestamp_ms = ts;
        r.spp_low      = lo;
        r.spp_high     = hi;
        midi_req_q.push_back(r);
        reqs_queued++;
    endtask

    task automatic push_clock(logic [31:0] ts);
        push_req(FUNC_CLOCK, ts, 7'($urandom), 7'($urandom));
    endtask

    task automatic push_cmd(logic [2:0] fn);
        push_req(fn, $urandom, 7'($urandom), 7'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_MARGIN)
            trk_margin = data;
        else
            trk_limit = data[7:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (reqs_accepted != reqs_queued || expected_status_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic next_clock();
        int k;
        int step;
        k = $urandom_range(99);
        if (k < 80) begin
            step = gen_base + int'($urandom_range(4)) - 2;
        end else if (k < 90) begin
            step = gen_base + int'($urandom_range(2 * gen_base + 20));
        end else if (k < 94) begin
            step = 0;
        end else if (k < 97) begin
            gen_base = ($urandom_range(9) < 8) ? int'($urandom_range(1, 40))
                                               : int'($urandom_range(41, 3000));
            step = gen_base;
        end else if (k < 99) begin
            gen_now = $urandom;
            step    = 0;
        end else begin
            gen_now = 32'hFFFF_FF80;
            step    = 0;
        end
        if (step < 0)
            step = 0;
        gen_now = gen_now + 32'(step);
        push_clock(gen_now);
    endtask

    // mostly song-like traffic: clocks at a steady rate, transport and stop
    // sequences of varying length, some long enough to expire, plus some raw noise
    task automatic gen_traffic(int n);
        int start_cnt;
        int r;
        int hk;
        start_cnt = reqs_queued;
        while (reqs_queued - start_cnt < n) begin
            r = $urandom_range(99);
            if (r < 64) begin
                next_clock();
            end else if (r < 72) begin
                push_cmd(FUNC_HK_TICK);
            end else if (r < 78) begin
                push_cmd(FUNC_STOP);
                hk = $urandom_range(2, 7);
                repeat (hk) begin
                    if ($urandom_range(1))
                        next_clock();
                    push_cmd(FUNC_HK_TICK);
                end
            end else if (r < 83) begin
                push_cmd(FUNC_START);
            end else if (r < 87) begin
                push_cmd(FUNC_CONTINUE);
            end else if (r < 92) begin
                push_req(FUNC_SPP, $urandom, 7'($urandom), 7'($urandom));
            end else begin
                push_req(3'($urandom_range(7)), $urandom, 7'($urandom), 7'($urandom));
            end
        end
    endtask

    task automatic run_phase(logic [15:0] margin, logic [7:0] lim, int send_pct,
                             int recv_pct, int n, logic hold);
        wait_idle();
        write_reg(CFG_MARGIN, margin);
        write_reg(CFG_LIMIT, {8'($urandom_range(255)), lim});
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        gen_traffic(n);
        if (hold)
            hold_req = 1'b1;
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 19;
        recv_idle_pct = 86;

        // directed: first-clock handling, zero interval, song position
        // extremes, reserved codes, stop countdown past zero, timestamp wrap
        push_cmd(FUNC_START);
        push_clock(32'd0);
        push_clock(32'd100);
        push_clock(32'd120);
        push_clock(32'd140);
        push_clock(32'd140);
        push_clock(32'd161);
        push_req(FUNC_SPP, $urandom, 7'd127, 7'd127);
        push_req(FUNC_SPP, $urandom, 7'd0, 7'd0);
        push_req(FUNC_SPP, $urandom, 7'd3, 7'd0);
        push_cmd(FUNC_RSVD6);
        push_cmd(FUNC_RSVD7);
        push_cmd(FUNC_CONTINUE);
        push_cmd(FUNC_STOP);
        repeat (6) push_cmd(FUNC_HK_TICK);
        push_cmd(FUNC_CONTINUE);
        push_clock(32'hFFFF_FFF0);
        push_clock(32'h0000_0004);
        push_clock(32'hFFFF_FFFF);
        gen_traffic(300);

        run_phase(16'd0, 8'd0, 19, 86, 250, 1'b0);
        run_phase(16'hFFFF, 8'hFF, 86, 19, 250, 1'b0);
        run_phase(16'd2, 8'd1, 86, 19, 250, 1'b0);
        run_phase(16'd5, 8'd3, 0, 0, 300, 1'b1);
        run_phase(16'($urandom_range(1, 12)), 8'($urandom_range(0, 6)), 0, 0, 200, 1'b0);
        run_phase(16'd1, 8'd2, 0, 0, 200, 1'b0);

        wait_idle();
        repeat (50) @(negedge i_clk);
        if (expected_status_q.size() != 0) begin
            $error("%0d results never arrived", expected_status_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("midi_clock_tempo_tracker test passed");
        end else begin
            $display("midi_clock_tempo_tracker test failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("midi_clock_tempo_tracker test failed");
        $finish;
    end

endmodule
